@@ rtl/rrwt_pkg.sv @@
// Shared types, widths and microcode table of the round-robin wait time unit.
package rrwt_pkg;

  localparam int unsigned MAX_PROCS = 16;
  localparam int unsigned IDX_W     = $clog2(MAX_PROCS);
  localparam int unsigned COUNT_W   = $clog2(MAX_PROCS + 1);
  localparam int unsigned BURST_W   = 16;
  localparam int unsigned TIME_W    = 20;
  localparam int unsigned TOTAL_W   = 24;
  localparam int unsigned PIDX_W    = 4;
  localparam int unsigned UADDR_W   = 3;

  localparam logic [BURST_W-1:0] QUANTUM_RESET = 16'd4;

  // Datapath operations selected by the control word.
  typedef enum logic [2:0] {
    OP_NOP       = 3'd0,
    OP_LOAD      = 3'd1,
    OP_PASS_INIT = 3'd2,
    OP_VISIT     = 3'd3,
    OP_OUT_INIT  = 3'd4,
    OP_OUT_W     = 3'd5,
    OP_EMIT      = 3'd6
  } op_e;

  // Jump conditions.
  typedef enum logic [2:0] {
    COND_NONE      = 3'd0,
    COND_START_END = 3'd1,
    COND_PASS_END  = 3'd2,
    COND_ANY       = 3'd3,
    COND_LAST_OUT  = 3'd4
  } cond_e;

  // Microcode addresses.
  localparam logic [UADDR_W-1:0] S_IDLE     = 3'd0;
  localparam logic [UADDR_W-1:0] S_PASS     = 3'd1;
  localparam logic [UADDR_W-1:0] S_VISIT    = 3'd2;
  localparam logic [UADDR_W-1:0] S_ROUND    = 3'd3;
  localparam logic [UADDR_W-1:0] S_OUT_INIT = 3'd4;
  localparam logic [UADDR_W-1:0] S_OUT_W    = 3'd5;
  localparam logic [UADDR_W-1:0] S_EMIT     = 3'd6;

  typedef struct packed {
    op_e                op;
    cond_e              cond;
    logic [UADDR_W-1:0] jump_to;
    logic [UADDR_W-1:0] next;
  } ucode_t;

  typedef struct packed {
    op_e                op;
    logic [BURST_W-1:0] quantum;
  } rrwt_ctrl_t;

  typedef struct packed {
    logic pass_end;
    logic any_busy;
    logic last_out;
  } rrwt_stat_t;

  // The program: load until the final item, sweep passes until nothing is left,
  // then emit one result per process in two steps each.
  function automatic ucode_t ucode_rom(input logic [UADDR_W-1:0] addr);
    ucode_t w;
    case (addr)
      S_IDLE:     w = '{OP_LOAD,      COND_START_END, S_PASS,     S_IDLE};
      S_PASS:     w = '{OP_PASS_INIT, COND_NONE,      S_VISIT,    S_VISIT};
      S_VISIT:    w = '{OP_VISIT,     COND_PASS_END,  S_ROUND,    S_VISIT};
      S_ROUND:    w = '{OP_NOP,       COND_ANY,       S_PASS,     S_OUT_INIT};
      S_OUT_INIT: w = '{OP_OUT_INIT,  COND_NONE,      S_OUT_W,    S_OUT_W};
      S_OUT_W:    w = '{OP_OUT_W,     COND_NONE,      S_EMIT,     S_EMIT};
      S_EMIT:     w = '{OP_EMIT,      COND_LAST_OUT,  S_IDLE,     S_OUT_W};
      default:    w = '{OP_NOP,       COND_NONE,      S_IDLE,     S_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/round_robin_wait_time_calc_unit.sv @@
// Top level of the round-robin wait time unit: microcode sequencer, quantum register, datapath.
//
//  channel   direction  handshake                      payload
//  command   in         start, busy                    burst_time_i, last_process_i
//  config    in         cfg_valid_i, cfg_ready_o       cfg_data_i (time quantum)
//  result    out        result_valid_o (one cycle)     index, wait, turnaround, totals, flags
//
// While idle the unit takes one burst time per cycle into its process store.
// The final item starts the schedule: each pass runs S_PASS, then S_VISIT for every process
// and once more for the pass end, then S_ROUND for the round check; passes repeat until every
// process has finished, then S_OUT_INIT and, per process, S_OUT_W and S_EMIT emit results.
// busy stays high from the final item until the last result is on the ports.
// Reset clears the control state and sets the quantum to 4; results cannot be stalled.
module round_robin_wait_time_calc_unit
  import rrwt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [BURST_W-1:0]  burst_time_i,
  input  logic                last_process_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [BURST_W-1:0]  cfg_data_i,
  output logic                result_valid_o,
  output logic [PIDX_W-1:0]   process_index_o,
  output logic [TIME_W-1:0]   waiting_time_o,
  output logic [TIME_W-1:0]   turnaround_time_o,
  output logic [TOTAL_W-1:0]  total_waiting_o,
  output logic [TOTAL_W-1:0]  total_turnaround_o,
  output logic                overflowed_o,
  output logic                end_of_run_o
);

  logic [UADDR_W-1:0] step_q, step_d;
  logic [BURST_W-1:0] quantum_q;
  ucode_t             uword;
  rrwt_ctrl_t         ctrl;
  rrwt_stat_t         stat;
  logic               take_jump;

  assign uword       = ucode_rom(step_q);
  assign busy        = (step_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // The load step only acts on a cycle that actually carries a transaction.
  assign ctrl.op      = (uword.op == OP_LOAD && !start) ? OP_NOP : uword.op;
  assign ctrl.quantum = quantum_q;

  always_comb begin
    case (uword.cond)
      COND_NONE:      take_jump = 1'b0;
      COND_START_END: take_jump = start && last_process_i;
      COND_PASS_END:  take_jump = stat.pass_end;
      COND_ANY:       take_jump = stat.any_busy;
      COND_LAST_OUT:  take_jump = stat.last_out;
      default:        take_jump = 1'b0;
    endcase
    step_d = take_jump ? uword.jump_to : uword.next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= S_IDLE;
      quantum_q <= QUANTUM_RESET;
    end else begin
      step_q <= step_d;
      if (cfg_valid_i && cfg_ready_o) begin
        quantum_q <= cfg_data_i;
      end
    end
  end

  rrwt_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ctrl_i             (ctrl),
    .burst_time_i       (burst_time_i),
    .stat_o             (stat),
    .result_valid_o     (result_valid_o),
    .process_index_o    (process_index_o),
    .waiting_time_o     (waiting_time_o),
    .turnaround_time_o  (turnaround_time_o),
    .total_waiting_o    (total_waiting_o),
    .total_turnaround_o (total_turnaround_o),
    .overflowed_o       (overflowed_o),
    .end_of_run_o       (end_of_run_o)
  );

`ifndef SYNTHESIS
  // A final item always starts the schedule.
  a_start_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && last_process_i) |=> busy)
    else $error("final item did not start the schedule");

  // Each result takes two sequencer steps, so strobes never come back to back.
  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobes in consecutive cycles");

  // The run's final result returns the unit to idle.
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && end_of_run_o) |-> !busy)
    else $error("unit still busy after the final result");

  // Results appear only after a run was under way.
  a_valid_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result strobe without a run");
`endif

endmodule

@@ rtl/rrwt_datapath.sv @@
// Datapath of the round-robin wait time unit: process stores, scheduler arithmetic, result registers.
module rrwt_datapath
  import rrwt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rrwt_ctrl_t          ctrl_i,
  input  logic [BURST_W-1:0]  burst_time_i,
  output rrwt_stat_t          stat_o,
  output logic                result_valid_o,
  output logic [PIDX_W-1:0]   process_index_o,
  output logic [TIME_W-1:0]   waiting_time_o,
  output logic [TIME_W-1:0]   turnaround_time_o,
  output logic [TOTAL_W-1:0]  total_waiting_o,
  output logic [TOTAL_W-1:0]  total_turnaround_o,
  output logic                overflowed_o,
  output logic                end_of_run_o
);

  logic [BURST_W-1:0] burst_mem [MAX_PROCS];
  logic [BURST_W-1:0] rem_mem   [MAX_PROCS];
  logic [TIME_W-1:0]  fin_mem   [MAX_PROCS];

  logic [COUNT_W-1:0] count_q, count_d;
  logic [COUNT_W-1:0] idx_q, idx_d;
  logic [TIME_W-1:0]  elapsed_q, elapsed_d;
  logic               ovf_q, ovf_d;
  logic               any_q, any_d;
  logic [TOTAL_W-1:0] tot_w_q, tot_w_d;
  logic [TOTAL_W-1:0] tot_t_q, tot_t_d;
  logic [TIME_W-1:0]  wait_q;

  logic [IDX_W-1:0]   rd_idx;
  logic [BURST_W-1:0] cur_rem;
  logic [BURST_W-1:0] cur_burst;
  logic [TIME_W-1:0]  cur_fin;
  logic [BURST_W-1:0] q_eff;
  logic               serve_full;
  logic [BURST_W-1:0] serve_amt;
  logic [TIME_W-1:0]  elapsed_sum;
  logic               pass_end;
  logic               last_out;
  logic               can_load;
  logic               visit_live;
  logic [TOTAL_W-1:0] sum_w;
  logic [TOTAL_W-1:0] sum_t;

  assign rd_idx    = idx_q[IDX_W-1:0];
  assign cur_rem   = rem_mem[rd_idx];
  assign cur_burst = burst_mem[rd_idx];
  assign cur_fin   = fin_mem[rd_idx];

  // A quantum of zero behaves as a quantum of one.
  assign q_eff       = (ctrl_i.quantum == '0) ? BURST_W'(1) : ctrl_i.quantum;
  assign serve_full  = cur_rem > q_eff;
  assign serve_amt   = serve_full ? q_eff : cur_rem;
  assign elapsed_sum = elapsed_q + TIME_W'(serve_amt);

  assign pass_end   = (idx_q == count_q);
  assign last_out   = ((idx_q + COUNT_W'(1)) == count_q);
  assign can_load   = (count_q < COUNT_W'(MAX_PROCS));
  assign visit_live = !pass_end && (cur_rem != '0);

  assign sum_w = tot_w_q + TOTAL_W'(wait_q);
  assign sum_t = tot_t_q + TOTAL_W'(cur_fin);

  assign stat_o = '{pass_end: pass_end, any_busy: any_q, last_out: last_out};

  always_comb begin
    count_d   = count_q;
    idx_d     = idx_q;
    elapsed_d = elapsed_q;
    ovf_d     = ovf_q;
    any_d     = any_q;
    tot_w_d   = tot_w_q;
    tot_t_d   = tot_t_q;
    case (ctrl_i.op)
      OP_LOAD: begin
        if (can_load) begin
          count_d = count_q + COUNT_W'(1);
        end else begin
          ovf_d = 1'b1;
        end
      end
      OP_PASS_INIT: begin
        idx_d = '0;
        any_d = 1'b0;
      end
      OP_VISIT: begin
        if (!pass_end) begin
          idx_d = idx_q + COUNT_W'(1);
        end
        if (visit_live) begin
          any_d     = 1'b1;
          elapsed_d = elapsed_sum;
        end
      end
      OP_OUT_INIT: begin
        idx_d   = '0;
        tot_w_d = '0;
        tot_t_d = '0;
      end
      OP_EMIT: begin
        tot_w_d = sum_w;
        tot_t_d = sum_t;
        if (last_out) begin
          count_d   = '0;
          elapsed_d = '0;
          ovf_d     = 1'b0;
        end else begin
          idx_d = idx_q + COUNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      idx_q          <= '0;
      elapsed_q      <= '0;
      ovf_q          <= 1'b0;
      any_q          <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      count_q        <= count_d;
      idx_q          <= idx_d;
      elapsed_q      <= elapsed_d;
      ovf_q          <= ovf_d;
      any_q          <= any_d;
      result_valid_o <= (ctrl_i.op == OP_EMIT);
    end
  end

  // Process stores. A load writes the finish time as zero so a zero burst
  // reports zero waiting and zero turnaround without ever being served.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == OP_LOAD && can_load) begin
      burst_mem[count_q[IDX_W-1:0]] <= burst_time_i;
      rem_mem[count_q[IDX_W-1:0]]   <= burst_time_i;
      fin_mem[count_q[IDX_W-1:0]]   <= '0;
    end else if (ctrl_i.op == OP_VISIT && visit_live) begin
      if (serve_full) begin
        rem_mem[rd_idx] <= cur_rem - q_eff;
      end else begin
        rem_mem[rd_idx] <= '0;
        fin_mem[rd_idx] <= elapsed_sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tot_w_q <= tot_w_d;
    tot_t_q <= tot_t_d;
    if (ctrl_i.op == OP_OUT_W) begin
      wait_q <= cur_fin - TIME_W'(cur_burst);
    end
    if (ctrl_i.op == OP_EMIT) begin
      process_index_o    <= PIDX_W'(idx_q);
      waiting_time_o     <= wait_q;
      turnaround_time_o  <= cur_fin;
      total_waiting_o    <= last_out ? sum_w : '0;
      total_turnaround_o <= last_out ? sum_t : '0;
      overflowed_o       <= ovf_q;
      end_of_run_o       <= last_out;
    end
  end

endmodule

@@ bench/round_robin_wait_time_calc_unit_checker.sv @@
// Checker for the round-robin wait time unit: predicts each schedule and compares every result.
module round_robin_wait_time_calc_unit_checker
  import rrwt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic [BURST_W-1:0]  burst_time_i,
  input  logic                last_process_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [BURST_W-1:0]  cfg_data_i,
  input  logic                result_valid_i,
  input  logic [PIDX_W-1:0]   process_index_i,
  input  logic [TIME_W-1:0]   waiting_time_i,
  input  logic [TIME_W-1:0]   turnaround_time_i,
  input  logic [TOTAL_W-1:0]  total_waiting_i,
  input  logic [TOTAL_W-1:0]  total_turnaround_i,
  input  logic                overflowed_i,
  input  logic                end_of_run_i,
  output int unsigned         mismatches_o,
  output int unsigned         awaited_o,
  output int unsigned         results_seen_o
);

  typedef struct packed {
    logic [PIDX_W-1:0]  pidx;
    logic [TIME_W-1:0]  waited;
    logic [TIME_W-1:0]  turnaround;
    logic [TOTAL_W-1:0] sum_waited;
    logic [TOTAL_W-1:0] sum_turnaround;
    logic               overflowed;
    logic               last;
  } sched_result_t;

  sched_result_t      due_results[$];
  logic [BURST_W-1:0] quantum_q;
  logic [BURST_W-1:0] burst_mem [MAX_PROCS];
  logic [BURST_W-1:0] left_mem  [MAX_PROCS];
  logic [TIME_W-1:0]  waited_mem[MAX_PROCS];
  int unsigned        loaded;
  logic               dropped;
  int unsigned        mismatch_count;
  int unsigned        results_seen;

  assign mismatches_o   = mismatch_count;
  assign results_seen_o = results_seen;

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= 30)
        $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Plays the round-robin schedule over the loaded processes and queues one result each.
  task automatic play_schedule();
    logic [BURST_W-1:0] slice;
    logic [TIME_W-1:0]  clock_now;
    logic [TOTAL_W-1:0] sum_w;
    logic [TOTAL_W-1:0] sum_t;
    logic               active;
    sched_result_t      r;
    slice = (quantum_q == '0) ? BURST_W'(1) : quantum_q;
    clock_now = '0;
    active = 1'b1;
    while (active) begin
      active = 1'b0;
      for (int i = 0; i < loaded; i++) begin
        if (left_mem[i] != '0) begin
          active = 1'b1;
          if (left_mem[i] > slice) begin
            clock_now = clock_now + TIME_W'(slice);
            left_mem[i] = left_mem[i] - slice;
          end else begin
            clock_now = clock_now + TIME_W'(left_mem[i]);
            waited_mem[i] = clock_now - TIME_W'(burst_mem[i]);
            left_mem[i] = '0;
          end
        end
      end
    end
    sum_w = '0;
    sum_t = '0;
    for (int i = 0; i < loaded; i++) begin
      r.pidx       = PIDX_W'(i);
      r.waited     = waited_mem[i];
      r.turnaround = TIME_W'(burst_mem[i]) + waited_mem[i];
      sum_w        = sum_w + TOTAL_W'(r.waited);
      sum_t        = sum_t + TOTAL_W'(r.turnaround);
      r.last       = (i + 1 == loaded);
      r.sum_waited     = r.last ? sum_w : '0;
      r.sum_turnaround = r.last ? sum_t : '0;
      r.overflowed = dropped;
      due_results.push_back(r);
    end
    loaded  = 0;
    dropped = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    sched_result_t head;
    if (!rst_ni) begin
      due_results.delete();
      quantum_q      = QUANTUM_RESET;
      loaded         = 0;
      dropped        = 1'b0;
      mismatch_count = 0;
      results_seen   = 0;
      awaited_o      = 0;
    end else begin
      // Results are compared before the new transaction is predicted, so a result and
      // an item accepted at the same edge keep their order.
      if (result_valid_i) begin
        results_seen++;
        if (due_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 30)
            $display("%0t: result for process %0d arrived with none expected",
                     $time, process_index_i);
        end else begin
          head = due_results.pop_front();
          check_field("process_index", head.pidx, process_index_i);
          check_field("waiting_time", head.waited, waiting_time_i);
          check_field("turnaround_time", head.turnaround, turnaround_time_i);
          check_field("total_waiting", head.sum_waited, total_waiting_i);
          check_field("total_turnaround", head.sum_turnaround, total_turnaround_i);
          check_field("overflowed", head.overflowed, overflowed_i);
          check_field("end_of_run", head.last, end_of_run_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i)
        quantum_q = cfg_data_i;
      if (start_i && !busy_i) begin
        if (loaded < MAX_PROCS) begin
          burst_mem[loaded]  = burst_time_i;
          left_mem[loaded]   = burst_time_i;
          waited_mem[loaded] = '0;
          loaded++;
        end else begin
          dropped = 1'b1;
        end
        if (last_process_i)
          play_schedule();
      end
      awaited_o = due_results.size();
    end
  end

endmodule

@@ bench/round_robin_wait_time_calc_unit_tb.sv @@
// Testbench top of the round-robin wait time unit: clock, reset, stimulus and verdict.
module round_robin_wait_time_calc_unit_tb;
  import rrwt_pkg::*;

  // The slowest run of this bench is dominated by one process of maximum burst at a
  // quantum of one; the limit leaves a wide margin over that.
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int unsigned RANDOM_ITEMS = 400;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [BURST_W-1:0] burst_time_i = '0;
  logic               last_process_i = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [BURST_W-1:0] cfg_data_i = '0;
  logic               result_valid_o;
  logic [PIDX_W-1:0]  process_index_o;
  logic [TIME_W-1:0]  waiting_time_o;
  logic [TIME_W-1:0]  turnaround_time_o;
  logic [TOTAL_W-1:0] total_waiting_o;
  logic [TOTAL_W-1:0] total_turnaround_o;
  logic               overflowed_o;
  logic               end_of_run_o;

  int unsigned mismatches;
  int unsigned awaited;
  int unsigned results_seen;

  int unsigned        items_sent;
  int unsigned        runs_sent;
  int unsigned        overflow_runs;
  int unsigned        quantum_writes;
  logic [BURST_W-1:0] quantum_now;
  logic [BURST_W-1:0] run_bursts[$];

  always #1 clk_i = ~clk_i;

  round_robin_wait_time_calc_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .burst_time_i      (burst_time_i),
    .last_process_i    (last_process_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .result_valid_o    (result_valid_o),
    .process_index_o   (process_index_o),
    .waiting_time_o    (waiting_time_o),
    .turnaround_time_o (turnaround_time_o),
    .total_waiting_o   (total_waiting_o),
    .total_turnaround_o(total_turnaround_o),
    .overflowed_o      (overflowed_o),
    .end_of_run_o      (end_of_run_o)
  );

  round_robin_wait_time_calc_unit_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start),
    .busy_i            (busy),
    .burst_time_i      (burst_time_i),
    .last_process_i    (last_process_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .result_valid_i    (result_valid_o),
    .process_index_i   (process_index_o),
    .waiting_time_i    (waiting_time_o),
    .turnaround_time_i (turnaround_time_o),
    .total_waiting_i   (total_waiting_o),
    .total_turnaround_i(total_turnaround_o),
    .overflowed_i      (overflowed_o),
    .end_of_run_i      (end_of_run_o),
    .mismatches_o      (mismatches),
    .awaited_o         (awaited),
    .results_seen_o    (results_seen)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_cycles();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 11) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // All tasks below start and end at a falling clock edge.
  task automatic idle_for(input int unsigned cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) begin
        burst_time_i   <= BURST_W'($urandom);
        last_process_i <= 1'($urandom);
        @(negedge clk_i);
      end
    end
  endtask

  task automatic send_burst(input logic [BURST_W-1:0] burst, input logic fin);
    start          <= 1'b1;
    burst_time_i   <= burst;
    last_process_i <= fin;
    // busy read right after the edge still holds its value from before the edge.
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    items_sent++;
  endtask

  // Sends the queued burst times as one process set, the final one marked last.
  task automatic play_run(input bit tight);
    for (int i = 0; i < run_bursts.size(); i++) begin
      if (!tight) idle_for(gap_cycles());
      send_burst(run_bursts[i], i + 1 == run_bursts.size());
    end
    runs_sent++;
    if (run_bursts.size() > MAX_PROCS) overflow_runs++;
    run_bursts.delete();
  endtask

  // Holds the sender until every predicted result has come and the unit is idle again.
  task automatic drain();
    start <= 1'b0;
    while (awaited != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_quantum(input logic [BURST_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= BURST_W'($urandom);
    quantum_now = value;
    quantum_writes++;
  endtask

  function automatic logic [BURST_W-1:0] pick_quantum();
    case ($urandom_range(0, 7))
      0:       return BURST_W'(1);
      1:       return BURST_W'(2);
      2:       return BURST_W'(3);
      3:       return BURST_W'($urandom_range(4, 64));
      4:       return BURST_W'($urandom_range(65, 4096));
      5:       return BURST_W'($urandom_range(4097, 65535));
      6:       return '1;
      default: return '0;
    endcase
  endfunction

  // Builds a random process set whose bursts stay within a bounded number of rounds.
  task automatic build_random_run();
    int unsigned count;
    int unsigned rounds;
    int unsigned cap;
    int unsigned slice;
    int unsigned roll;
    count  = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
    rounds = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
    slice  = (quantum_now == '0) ? 1 : quantum_now;
    cap    = slice * rounds;
    if (cap > 65535) cap = 65535;
    repeat (count) begin
      roll = $urandom_range(0, 9);
      if (roll == 0)      run_bursts.push_back('0);
      else if (roll == 1) run_bursts.push_back(BURST_W'(cap));
      else                run_bursts.push_back(BURST_W'($urandom_range(0, cap)));
    end
  endtask

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("round_robin_wait_time_calc_unit test failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned random_base;
    items_sent     = 0;
    runs_sent      = 0;
    overflow_runs  = 0;
    quantum_writes = 0;
    quantum_now    = QUANTUM_RESET;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Quantum left at its reset value: a zero burst, one exactly a quantum, a zero last.
    run_bursts = '{16'd5, 16'd0, 16'd4, 16'd9, 16'd0};
    play_run(1'b0);
    drain();
    // A zero quantum acts as one; a single maximum burst then takes every round.
    write_quantum('0);
    run_bursts = '{16'hFFFF};
    play_run(1'b1);
    drain();
    write_quantum('1);
    run_bursts = '{16'h0000, 16'hFFFF};
    play_run(1'b0);
    drain();
    // Full store, then a last item that is dropped but still starts the schedule.
    write_quantum(16'd7);
    repeat (MAX_PROCS + 1) run_bursts.push_back(BURST_W'($urandom_range(0, 30)));
    play_run(1'b0);
    drain();

    random_base = items_sent;
    while (items_sent < random_base + RANDOM_ITEMS) begin
      write_quantum(pick_quantum());
      repeat ($urandom_range(1, 6)) begin
        build_random_run();
        play_run($urandom_range(0, 3) == 0);
        idle_for(gap_cycles());
      end
      drain();
    end

    while (awaited != 0) @(negedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("Sent %0d burst times in %0d process sets (%0d overfilled) over %0d quantum writes.",
             items_sent, runs_sent, overflow_runs, quantum_writes);
    $display("Compared %0d per-process results with the predicted schedule.", results_seen);
    if (mismatches == 0 && awaited == 0) begin
      $display("round_robin_wait_time_calc_unit test passed");
    end else begin
      $display("round_robin_wait_time_calc_unit test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/rrwt_pkg.sv
rtl/rrwt_datapath.sv
rtl/round_robin_wait_time_calc_unit.sv
bench/round_robin_wait_time_calc_unit_checker.sv
bench/round_robin_wait_time_calc_unit_tb.sv
